[rtl/mmf_pkg.sv]
// ----------------------------------------------------------------------------
// mmf_pkg - shared types for the multiset mode finder
// Controller states, and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package mmf_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_COUNT,
		ST_CDRAIN,
		ST_TALLY,
		ST_TDRAIN,
		ST_DECIDE,
		ST_NOMODE,
		ST_ERD,
		ST_ECHK
	} mmf_state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_rdy;       // take input items into the store
		logic pair_issue;   // issue one (i, j) compare pair
		logic scan_issue;   // issue one tally read
		logic idx_inc;      // step the emit index
		logic push_mode;    // load a mode result into the output register
		logic push_nomode;  // load the no-mode result into the output register
		logic finish;       // close the evaluation, empty the store
	} mmf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic close;        // closing item offered; transfers while loading
		logic pair_last;    // last compare pair is being issued
		logic idx_last;     // index points at the last stored item
		logic all_eq;       // every stored item reaches the highest count
		logic qual;         // current entry is the first copy of a mode
		logic slot_free;    // output register can take a result
		logic emit_last;    // next mode result is the final one
	} mmf_sts_t;

endpackage

[rtl/mmf_ctrl.sv]
// ----------------------------------------------------------------------------
// mmf_ctrl - sequencer of the multiset mode finder
// Steps through load, pairwise count, tally, decision and emission phases.
// ----------------------------------------------------------------------------
module mmf_ctrl
	import mmf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mmf_sts_t sts,
	output mmf_cmd_t cmd
);

	mmf_state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_LOAD: begin
				if (sts.close) state_nx = ST_COUNT;
			end
			ST_COUNT: begin
				if (sts.pair_last) state_nx = ST_CDRAIN;
			end
			ST_CDRAIN: state_nx = ST_TALLY;
			ST_TALLY: begin
				if (sts.idx_last) state_nx = ST_TDRAIN;
			end
			ST_TDRAIN: state_nx = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.all_eq) state_nx = ST_NOMODE;
				else state_nx = ST_ERD;
			end
			ST_NOMODE: begin
				if (sts.slot_free) state_nx = ST_LOAD;
			end
			ST_ERD: state_nx = ST_ECHK;
			ST_ECHK: begin
				if (!sts.qual) begin
					state_nx = ST_ERD;
				end else if (sts.slot_free) begin
					if (sts.emit_last) state_nx = ST_LOAD;
					else state_nx = ST_ERD;
				end
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD:  cmd.in_rdy = 1'b1;
			ST_COUNT: cmd.pair_issue = 1'b1;
			ST_TALLY: cmd.scan_issue = 1'b1;
			ST_NOMODE: begin
				cmd.push_nomode = sts.slot_free;
				cmd.finish      = sts.slot_free;
			end
			ST_ECHK: begin
				cmd.idx_inc   = !sts.qual || sts.slot_free;
				cmd.push_mode = sts.qual && sts.slot_free;
				cmd.finish    = sts.qual && sts.slot_free && sts.emit_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/mmf_dpath.sv]
// ----------------------------------------------------------------------------
// mmf_dpath - datapath of the multiset mode finder
// Value store, per-item hit counts, pairwise comparator, tallies and the
// output register.
// ----------------------------------------------------------------------------
module mmf_dpath
	import mmf_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mmf_cmd_t          cmd,
	output mmf_sts_t          sts,
	input  logic              in_valid,
	input  logic [DATA_W-1:0] item_value,
	input  logic              item_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] mode_value,
	output logic              no_mode,
	output logic              overflowed,
	output logic              result_last
);

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	// Stores
	logic [DATA_W-1:0] val_mem [MAX_ITEMS];
	logic [CW-1:0]     hcnt_mem [MAX_ITEMS];
	logic              hfirst_mem [MAX_ITEMS];

	logic [DATA_W-1:0] a_rd_q, b_rd_q;
	logic [CW-1:0]     hcnt_rd_q;
	logic              hfirst_rd_q;

	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [IW-1:0]     i_q, j_q;

	logic              cmp_vld_s1, cmp_jlast_s1, cmp_before_s1;
	logic [IW-1:0]     cmp_i_s1;
	logic [CW-1:0]     acc_q, best_q;
	logic              first_q;
	logic              tal_vld_s1;
	logic [CW-1:0]     at_best_q, modes_q, emit_q;

	logic              out_vld_q;
	logic [DATA_W-1:0] mode_value_q;
	logic              no_mode_q, overflowed_q, result_last_q;

	logic              accept, closing, full, eq, first_nx, j_last;
	logic [CW-1:0]     cnt_m1, acc_nx, emit_p1;
	logic [IW-1:0]     last_idx;

	assign accept   = in_valid && cmd.in_rdy;
	assign closing  = accept && item_last;
	assign full     = (cnt_q == CW'(MAX_ITEMS));
	assign cnt_m1   = cnt_q - CW'(1);
	assign last_idx = cnt_m1[IW-1:0];
	assign j_last   = (j_q == last_idx);
	assign eq       = (a_rd_q == b_rd_q);
	assign acc_nx   = acc_q + CW'(eq);
	assign first_nx = first_q && !(eq && cmp_before_s1);
	assign emit_p1  = emit_q + CW'(1);

	// Status toward the controller
	always_comb begin
		sts.close     = in_valid && item_last;
		sts.idx_last  = (i_q == last_idx);
		sts.pair_last = sts.idx_last && j_last;
		sts.all_eq    = (at_best_q == cnt_q);
		sts.qual      = hfirst_rd_q && (hcnt_rd_q == best_q);
		sts.slot_free = !out_vld_q || out_ready;
		sts.emit_last = (emit_p1 == modes_q);
	end

	// Value store: write on load, two registered read ports
	always_ff @(posedge clk) begin
		if (accept && !full) val_mem[cnt_q[IW-1:0]] <= item_value;
		a_rd_q <= val_mem[i_q];
		b_rd_q <= val_mem[j_q];
	end

	// Hit count store: written as each item's count completes
	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && cmp_jlast_s1) begin
			hcnt_mem[cmp_i_s1]   <= acc_nx;
			hfirst_mem[cmp_i_s1] <= first_nx;
		end
		hcnt_rd_q   <= hcnt_mem[i_q];
		hfirst_rd_q <= hfirst_mem[i_q];
	end

	// Fill level and overflow flag of the current set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.finish) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (full) ovf_q <= 1'b1;
			else cnt_q <= cnt_q + CW'(1);
		end
	end

	// Scan indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (closing) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.pair_issue) begin
			if (j_last) begin
				j_q <= '0;
				i_q <= sts.idx_last ? '0 : i_q + IW'(1);
			end else begin
				j_q <= j_q + IW'(1);
			end
		end else if (cmd.scan_issue || cmd.idx_inc) begin
			i_q <= sts.idx_last ? '0 : i_q + IW'(1);
		end
	end

	// Compare stage: count equal pairs, track first appearance and best count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1    <= 1'b0;
			cmp_jlast_s1  <= 1'b0;
			cmp_before_s1 <= 1'b0;
			cmp_i_s1      <= '0;
			acc_q         <= '0;
			first_q       <= 1'b1;
			best_q        <= '0;
		end else begin
			cmp_vld_s1    <= cmd.pair_issue;
			cmp_jlast_s1  <= j_last;
			cmp_before_s1 <= (j_q < i_q);
			cmp_i_s1      <= i_q;
			if (closing) begin
				acc_q   <= '0;
				first_q <= 1'b1;
				best_q  <= '0;
			end else if (cmp_vld_s1) begin
				if (cmp_jlast_s1) begin
					acc_q   <= '0;
					first_q <= 1'b1;
					if (acc_nx > best_q) best_q <= acc_nx;
				end else begin
					acc_q   <= acc_nx;
					first_q <= first_nx;
				end
			end
		end
	end

	// Tally stage: items at the best count, distinct modes, modes emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tal_vld_s1 <= 1'b0;
			at_best_q  <= '0;
			modes_q    <= '0;
			emit_q     <= '0;
		end else begin
			tal_vld_s1 <= cmd.scan_issue;
			if (closing) begin
				at_best_q <= '0;
				modes_q   <= '0;
				emit_q    <= '0;
			end else begin
				if (tal_vld_s1 && (hcnt_rd_q == best_q)) begin
					at_best_q <= at_best_q + CW'(1);
					if (hfirst_rd_q) modes_q <= modes_q + CW'(1);
				end
				if (cmd.push_mode) emit_q <= emit_p1;
			end
		end
	end

	// Output register: hold a result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.push_mode || cmd.push_nomode) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_mode) begin
			mode_value_q  <= a_rd_q;
			no_mode_q     <= 1'b0;
			overflowed_q  <= ovf_q;
			result_last_q <= sts.emit_last;
		end else if (cmd.push_nomode) begin
			mode_value_q  <= '0;
			no_mode_q     <= 1'b1;
			overflowed_q  <= ovf_q;
			result_last_q <= 1'b1;
		end
	end

	assign out_valid   = out_vld_q;
	assign mode_value  = mode_value_q;
	assign no_mode     = no_mode_q;
	assign overflowed  = overflowed_q;
	assign result_last = result_last_q;

endmodule

[rtl/multiset_mode_finder.sv]
// ----------------------------------------------------------------------------
// multiset_mode_finder - most frequent values of a set of 32-bit words
// Loads a set one word per transfer, then emits each distinct mode once,
// in order of first appearance, or one no-mode result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, item_value, item_last) takes one word
//   per cycle while a set is loading; item_last closes the set. Words past
//   MAX_ITEMS are dropped and flagged on every result of that set.
//   Output channel (out_valid/out_ready) gives the results; result_last marks
//   the final one, no_mode marks the single result of a set whose items all
//   share one count.
//   After the closing transfer the block counts pairwise (one compare per
//   cycle on the two read ports of the value store), tallies, decides, then
//   loads a no-mode result, or scans the stored items until the last mode is
//   loaded. in_ready is low during that time and rises again once the final
//   result is loaded.
//   Reset leaves the store empty and the output register empty.
//   When the receiver stalls, the pending result is held in the output
//   register and the emission scan waits; a new set may start loading while
//   the final result of the previous one still waits.
// ----------------------------------------------------------------------------
module multiset_mode_finder
	import mmf_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] item_value,
	input  logic              item_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] mode_value,
	output logic              no_mode,
	output logic              overflowed,
	output logic              result_last
);

	mmf_cmd_t cmd;
	mmf_sts_t sts;

	// Sequencer
	mmf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Store, counters and output register
	mmf_dpath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_valid    (in_valid),
		.item_value  (item_value),
		.item_last   (item_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mode_value  (mode_value),
		.no_mode     (no_mode),
		.overflowed  (overflowed),
		.result_last (result_last)
	);

	assign in_ready = cmd.in_rdy;

endmodule

[rtl/mmf_checker.sv]
// ----------------------------------------------------------------------------
// mmf_checker - port-level checks of the multiset mode finder
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module mmf_checker
	import mmf_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              item_last,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] mode_value,
	input logic              no_mode,
	input logic              result_last
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode_value)
			&& $stable(no_mode) && $stable(result_last))
		else $error("stalled result changed");

	// A no-mode result stands alone and carries zero
	a_nomode_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_mode |-> result_last && (mode_value == '0))
		else $error("malformed no-mode result");

	// Closing transfer stops loading
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && item_last |=> !in_ready)
		else $error("input still ready after closing transfer");

	// No loading while results of a set are still being emitted
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_last |-> !in_ready)
		else $error("input ready during emission");

endmodule

bind multiset_mode_finder mmf_checker u_mmf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.item_last   (item_last),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.mode_value  (mode_value),
	.no_mode     (no_mode),
	.result_last (result_last)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for multiset_mode_finder
// Sends sets of 32-bit words over the input channel and predicts the modes
// of each set as it closes. Every result transfer is checked against the
// oldest predicted result. Coverage includes one-item sets, all-distinct
// sets, single-value sets, zero as a mode, extreme words, a large set of
// word pairs with no mode, and a set that overruns the store. Both channels
// idle in random bursts, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module testbench
	import mmf_pkg::*;
();

	localparam int STORE_DEPTH  = 64;
	localparam int TAIL_ITEMS   = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              closing;
	} load_item_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              no_mode;
		logic              overflowed;
		logic              is_last;
	} mode_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [DATA_W-1:0] item_value = '0;
	logic              item_last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DATA_W-1:0] mode_value;
	logic              no_mode;
	logic              overflowed;
	logic              result_last;

	load_item_t   pending_items [$];
	mode_result_t expected_modes [$];

	// predictor state: words of the open set and its overrun flag
	logic [DATA_W-1:0] set_store [STORE_DEPTH];
	int                set_fill = 0;
	logic              set_dropped = 1'b0;

	int   queued_items = 0;
	int   items_taken = 0;
	int   sets_closed = 0;
	int   sets_overrun = 0;
	int   results_checked = 0;
	int   errors = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   cycle_count = 0;
	logic calm = 1'b0;
	logic hold_off = 1'b0;

	multiset_mode_finder #(
		.MAX_ITEMS(STORE_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.item_value (item_value),
		.item_last  (item_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mode_value (mode_value),
		.no_mode    (no_mode),
		.overflowed (overflowed),
		.result_last(result_last)
	);

	always #2 clk = ~clk;

	// Store one word of the open set; on the closing word, predict the modes
	task automatic predict_modes(input logic [DATA_W-1:0] v, input logic closing);
		int           hits [STORE_DEPTH];
		int           best;
		int           at_best;
		int           n;
		int           i;
		int           j;
		bit           first_copy;
		mode_result_t r;
		mode_result_t found [$];
		if (set_fill < STORE_DEPTH) begin
			set_store[set_fill] = v;
			set_fill++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!closing)
			return;
		n = set_fill;
		best = 0;
		for (i = 0; i < n; i++) begin
			hits[i] = 0;
			for (j = 0; j < n; j++)
				if (set_store[j] == set_store[i])
					hits[i]++;
			if (hits[i] > best)
				best = hits[i];
		end
		at_best = 0;
		for (i = 0; i < n; i++)
			if (hits[i] == best)
				at_best++;
		if (n == 0 || at_best == n) begin
			r.value = '0;
			r.no_mode = 1'b1;
			r.overflowed = set_dropped;
			r.is_last = 1'b1;
			expected_modes.push_back(r);
		end else begin
			// keep only the first copy of each mode, in order of arrival
			for (i = 0; i < n; i++) begin
				if (hits[i] == best) begin
					first_copy = 1'b1;
					for (j = 0; j < i; j++)
						if (set_store[j] == set_store[i])
							first_copy = 1'b0;
					if (first_copy) begin
						r.value = set_store[i];
						r.no_mode = 1'b0;
						r.overflowed = set_dropped;
						r.is_last = 1'b0;
						found.push_back(r);
					end
				end
			end
			found[found.size() - 1].is_last = 1'b1;
			for (i = 0; i < found.size(); i++)
				expected_modes.push_back(found[i]);
		end
		sets_closed++;
		if (set_dropped)
			sets_overrun++;
		set_fill = 0;
		set_dropped = 1'b0;
	endtask

	task automatic add_item(input logic [DATA_W-1:0] v, input logic closing);
		load_item_t it;
		it.value = v;
		it.closing = closing;
		pending_items.push_back(it);
		queued_items++;
	endtask

	// Set of n words drawn from a pool of pool_n words; pool_n of 0 means fresh words
	task automatic add_set(input int n, input int pool_n);
		logic [DATA_W-1:0] pool [8];
		int                i;
		for (i = 0; i < 8; i++)
			pool[i] = $urandom;
		if ($urandom_range(0, 5) == 0)
			pool[0] = '0;
		if ($urandom_range(0, 7) == 0)
			pool[1] = '1;
		for (i = 0; i < n; i++)
			add_item(pool_n == 0 ? $urandom : pool[$urandom_range(0, pool_n - 1)],
				i == n - 1);
	endtask

	// Each of k distinct words twice: every word has count two, so the set has no mode
	task automatic add_pair_set(input int k);
		logic [DATA_W-1:0] words [$];
		int                i;
		for (i = 0; i < k; i++)
			words.push_back(($urandom & 32'hFFFF_FF00) | i);
		for (i = 0; i < 2 * k; i++)
			add_item(words[i % k], i == 2 * k - 1);
	endtask

	// Drive the input channel and predict on every accepted transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_modes(item_value, item_last);
				items_taken++;
			end
			calm <= (pending_items.size() <= TAIL_ITEMS);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 4) == 0) begin
					send_gap = $urandom_range(1, 11) - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_valid <= 1'b1;
					item_value <= pending_items[0].value;
					item_last <= pending_items[0].closing;
					void'(pending_items.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each result transfer and pace the output ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (expected_modes.size() == 0) begin
					errors++;
					$display("%0t: unexpected result value=%h no_mode=%b ovf=%b last=%b",
						$time, mode_value, no_mode, overflowed, result_last);
				end else begin
					if (mode_value !== expected_modes[0].value ||
					    no_mode !== expected_modes[0].no_mode ||
					    overflowed !== expected_modes[0].overflowed ||
					    result_last !== expected_modes[0].is_last) begin
						errors++;
						$display("%0t: expected value=%h no_mode=%b ovf=%b last=%b,",
							$time, expected_modes[0].value, expected_modes[0].no_mode,
							expected_modes[0].overflowed, expected_modes[0].is_last);
						$display("%0t: got value=%h no_mode=%b ovf=%b last=%b",
							$time, mode_value, no_mode, overflowed, result_last);
					end
					void'(expected_modes.pop_front());
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Hold off the receiver long enough to back up the input channel
	initial begin
		while (items_taken < 120)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_modes.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		// directed sets: single words at the extremes
		add_item(32'hFFFF_FFFF, 1'b1);
		add_item(32'h0000_0000, 1'b1);
		// all distinct, then one word repeated: no mode either way
		add_item(32'h0000_0001, 1'b0);
		add_item(32'h0000_0002, 1'b0);
		add_item(32'h0000_0003, 1'b1);
		add_item(32'h0000_0007, 1'b0);
		add_item(32'h0000_0007, 1'b0);
		add_item(32'h0000_0007, 1'b1);
		// zero as the only mode, seen three times
		add_item(32'h0000_0000, 1'b0);
		add_item(32'h0000_0005, 1'b0);
		add_item(32'h0000_0000, 1'b0);
		add_item(32'h0000_0000, 1'b1);
		// two modes, reported in order of first appearance
		add_item(32'h0000_0009, 1'b0);
		add_item(32'h0000_0004, 1'b0);
		add_item(32'h0000_0009, 1'b0);
		add_item(32'h0000_0004, 1'b0);
		add_item(32'h0000_0002, 1'b1);
		// extreme words with the all-ones word as mode
		add_item(32'hFFFF_FFFF, 1'b0);
		add_item(32'h8000_0000, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b1);

		// random sets, then the largest cases, then more random sets
		while (queued_items < 150)
			add_set($urandom_range(1, 12), $urandom_range(0, 6));
		add_pair_set(31);
		add_set(67, 4);
		while (queued_items < 380)
			add_set($urandom_range(1, 12), $urandom_range(0, 6));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_modes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words in %0d sets (%0d overrunning the store)",
			items_taken, sets_closed, sets_overrun);
		$display("Checked %0d results, %0d errors", results_checked, errors);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
